[design/idt_pkg.sv]
// ----------------------------------------------------------------------------
// idt_pkg: shared constants and types of the indent/dedent tracker
// widths, character codes, token kinds and the stack control structs
// ----------------------------------------------------------------------------
package idt_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int LEVEL_MAX   = 1023;
	localparam int LEVEL_W     = 10;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W       = $clog2(STACK_DEPTH);
	localparam int LINE_W      = 16;
	localparam int TAB_W       = 4;
	localparam int APB_DW      = 32;
	localparam int APB_AW      = 3;

	localparam logic [LINE_W-1:0]  LINE_MAX  = '1;
	localparam logic [TAB_W-1:0]   TAB_RESET = 4'd4;

	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_TAB     = 8'h09;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_END  = 1'b1;

	localparam logic REG_TAB_WIDTH = 1'b0;

	localparam logic [1:0] KIND_INDENT = 2'd0;
	localparam logic [1:0] KIND_DEDENT = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	typedef struct packed {
		logic               push;
		logic               pop;
		logic [LEVEL_W-1:0] push_level;
	} stk_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0]   count;
		logic               full;
		logic [LEVEL_W-1:0] top;
		logic [LEVEL_W-1:0] below;
	} stk_stat_t;

endpackage

[design/idt_if.sv]
// ----------------------------------------------------------------------------
// idt_if: valid/ready channels of the indent/dedent tracker
// one interface for source bytes, one for tokens
// ----------------------------------------------------------------------------
interface idt_in_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] char_in;

	modport source (output valid, output req_type, output char_in, input ready);
	modport sink (input valid, input req_type, input char_in, output ready);
endinterface

interface idt_out_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      token_kind;
	logic [idt_pkg::LEVEL_W-1:0]     indent_level;
	logic [idt_pkg::LINE_W-1:0]      line_number;
	logic                            last;

	modport source (output valid, output token_kind, output indent_level,
		output line_number, output last, input ready);
	modport sink (input valid, input token_kind, input indent_level,
		input line_number, input last, output ready);
endinterface

[design/idt_stack.sv]
// ----------------------------------------------------------------------------
// idt_stack: stack of indentation levels
// holds the stacked levels, the fill count and the current top; one push or
// one pop per cycle, the entry below the top is offered for the next pop
// ----------------------------------------------------------------------------
module idt_stack (
	input  logic                clk,
	input  logic                arst_n,
	input  idt_pkg::stk_cmd_t   cmd,
	output idt_pkg::stk_stat_t  stat
);

	logic [idt_pkg::LEVEL_W-1:0] level_q [idt_pkg::STACK_DEPTH];
	logic [idt_pkg::CNT_W-1:0]   count_q;
	logic [idt_pkg::LEVEL_W-1:0] top_q;
	logic [idt_pkg::CNT_W-1:0]   below_ptr;
	logic [idt_pkg::LEVEL_W-1:0] below;

	assign below_ptr = count_q - idt_pkg::CNT_W'(2);
	assign below = (count_q >= idt_pkg::CNT_W'(2)) ?
		level_q[below_ptr[idt_pkg::IDX_W-1:0]] : '0;

	assign stat.count = count_q;
	assign stat.full  = (count_q == idt_pkg::CNT_W'(idt_pkg::STACK_DEPTH));
	assign stat.top   = top_q;
	assign stat.below = below;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < idt_pkg::STACK_DEPTH; i++) begin
				level_q[i] <= '0;
			end
			count_q <= idt_pkg::CNT_W'(1);
			top_q   <= '0;
		end else if (cmd.push && !stat.full) begin
			level_q[count_q[idt_pkg::IDX_W-1:0]] <= cmd.push_level;
			count_q <= count_q + idt_pkg::CNT_W'(1);
			top_q   <= cmd.push_level;
		end else if (cmd.pop && count_q > idt_pkg::CNT_W'(1)) begin
			count_q <= count_q - idt_pkg::CNT_W'(1);
			top_q   <= below;
		end
	end

endmodule

[design/indent_dedent_tracker_top.sv]
// ----------------------------------------------------------------------------
// indent_dedent_tracker_top: offside-rule indentation tracker
// sums leading whitespace per line and turns level changes into indent,
// dedent and error tokens through a level stack and a small pop sequencer
// ----------------------------------------------------------------------------
//  channel   dir  transfer when           payload
//  in_ch     in   valid & ready           req_type, char_in
//  out_ch    out  valid & ready           token_kind, indent_level,
//                                         line_number, last
//  apb       in   psel&penable&pwrite     tab_width at byte address 0
//
//  an indent or error token is registered in the cycle its byte is taken
//  a dedent run gives one token per popped level plus a trailing error on mismatch;
//  the pop sequencer walks the level stack one entry a cycle while out_ch is not stalled
//  in_ch.ready is low while popping and while a token waits on a stalled out_ch
//  reset: empty line state, line 1, level stack holding level zero, tab width 4
// ----------------------------------------------------------------------------
module indent_dedent_tracker_top (
	input  logic                         clk,
	input  logic                         arst_n,
	idt_in_if.sink                       in_ch,
	idt_out_if.source                    out_ch,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [idt_pkg::APB_AW-1:0]   paddr,
	input  logic [idt_pkg::APB_DW-1:0]   pwdata,
	output logic [idt_pkg::APB_DW-1:0]   prdata,
	output logic                         pready
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_POP  = 1'b1;

	logic                          state_q, state_d;
	logic                          eos_q, eos_d;
	logic [idt_pkg::LEVEL_W-1:0]   lvl_q, lvl_d;
	logic [idt_pkg::LEVEL_W-1:0]   sum_q, sum_d;
	logic                          at_start_q, at_start_d;
	logic [idt_pkg::LINE_W-1:0]    line_q, line_d;
	logic [idt_pkg::TAB_W-1:0]     tab_width_q;

	logic                          out_valid_q, out_valid_d;
	logic [1:0]                    out_kind_q, out_kind_d;
	logic [idt_pkg::LEVEL_W-1:0]   out_level_q, out_level_d;
	logic [idt_pkg::LINE_W-1:0]    out_line_q, out_line_d;
	logic                          out_last_q, out_last_d;

	idt_pkg::stk_cmd_t             cmd;
	idt_pkg::stk_stat_t            stat;

	logic                          slot_free;
	logic                          in_ready;
	logic                          in_xfer;
	logic [idt_pkg::LEVEL_W:0]     sum_add;
	logic [idt_pkg::LEVEL_W:0]     amount;
	logic [idt_pkg::LEVEL_W-1:0]   sum_sat;
	logic                          pop_ok;
	logic                          next_pop;
	logic                          pop_last;
	logic                          cfg_wr;

	idt_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat)
	);

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == idt_pkg::REG_TAB_WIDTH) ?
		idt_pkg::APB_DW'(tab_width_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_width_q <= idt_pkg::TAB_RESET;
		end else if (cfg_wr && paddr[2] == idt_pkg::REG_TAB_WIDTH) begin
			tab_width_q <= pwdata[idt_pkg::TAB_W-1:0];
		end
	end

	assign slot_free = !out_valid_q || out_ch.ready;
	assign in_ready  = (state_q == ST_IDLE) && slot_free;
	assign in_xfer   = in_ch.valid && in_ready;
	assign in_ch.ready = in_ready;

	// shared saturating column adder
	assign amount  = (in_ch.char_in == idt_pkg::CHAR_TAB) ?
		(idt_pkg::LEVEL_W+1)'(tab_width_q) : (idt_pkg::LEVEL_W+1)'(1);
	assign sum_add = {1'b0, sum_q} + amount;
	assign sum_sat = (sum_add > (idt_pkg::LEVEL_W+1)'(idt_pkg::LEVEL_MAX)) ?
		idt_pkg::LEVEL_W'(idt_pkg::LEVEL_MAX) : sum_add[idt_pkg::LEVEL_W-1:0];

	// pop decision for the current and the following step
	assign pop_ok   = (stat.count > idt_pkg::CNT_W'(1)) && (eos_q || lvl_q < stat.top);
	assign next_pop = (stat.count > idt_pkg::CNT_W'(2)) && (eos_q || lvl_q < stat.below);
	assign pop_last = !next_pop && (eos_q || lvl_q == stat.below);

	always_comb begin
		state_d     = state_q;
		eos_d       = eos_q;
		lvl_d       = lvl_q;
		sum_d       = sum_q;
		at_start_d  = at_start_q;
		line_d      = line_q;
		cmd         = '0;
		out_valid_d = out_valid_q && !out_ch.ready;
		out_kind_d  = out_kind_q;
		out_level_d = out_level_q;
		out_line_d  = out_line_q;
		out_last_d  = out_last_q;

		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (in_ch.req_type == idt_pkg::REQ_END) begin
						if (stat.count > idt_pkg::CNT_W'(1)) begin
							state_d = ST_POP;
							eos_d   = 1'b1;
						end else begin
							line_d     = idt_pkg::LINE_W'(1);
							at_start_d = 1'b1;
							sum_d      = '0;
						end
					end else if (in_ch.char_in == idt_pkg::CHAR_NEWLINE) begin
						if (line_q != idt_pkg::LINE_MAX) begin
							line_d = line_q + idt_pkg::LINE_W'(1);
						end
						at_start_d = 1'b1;
						sum_d      = '0;
					end else if (at_start_q) begin
						if (in_ch.char_in == idt_pkg::CHAR_SPACE ||
							in_ch.char_in == idt_pkg::CHAR_TAB) begin
							sum_d = sum_sat;
						end else begin
							at_start_d = 1'b0;
							sum_d      = '0;
							if (sum_q > stat.top) begin
								out_valid_d = 1'b1;
								out_line_d  = line_q;
								out_last_d  = 1'b1;
								if (!stat.full) begin
									cmd.push       = 1'b1;
									cmd.push_level = sum_q;
									out_kind_d     = idt_pkg::KIND_INDENT;
									out_level_d    = sum_q;
								end else begin
									out_kind_d  = idt_pkg::KIND_ERROR;
									out_level_d = stat.top;
								end
							end else if (sum_q < stat.top) begin
								lvl_d   = sum_q;
								eos_d   = 1'b0;
								state_d = ST_POP;
							end
						end
					end
				end
			end
			ST_POP: begin
				if (slot_free) begin
					out_line_d = line_q;
					if (pop_ok) begin
						cmd.pop     = 1'b1;
						out_valid_d = 1'b1;
						out_kind_d  = idt_pkg::KIND_DEDENT;
						out_level_d = stat.below;
						out_last_d  = pop_last;
						if (pop_last) begin
							state_d = ST_IDLE;
							if (eos_q) begin
								line_d     = idt_pkg::LINE_W'(1);
								at_start_d = 1'b1;
								sum_d      = '0;
							end
						end
					end else begin
						state_d = ST_IDLE;
						if (eos_q) begin
							line_d     = idt_pkg::LINE_W'(1);
							at_start_d = 1'b1;
							sum_d      = '0;
						end else begin
							out_valid_d = 1'b1;
							out_kind_d  = idt_pkg::KIND_ERROR;
							out_level_d = stat.top;
							out_last_d  = 1'b1;
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			eos_q       <= 1'b0;
			sum_q       <= '0;
			at_start_q  <= 1'b1;
			line_q      <= idt_pkg::LINE_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			eos_q       <= eos_d;
			sum_q       <= sum_d;
			at_start_q  <= at_start_d;
			line_q      <= line_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		lvl_q       <= lvl_d;
		out_kind_q  <= out_kind_d;
		out_level_q <= out_level_d;
		out_line_q  <= out_line_d;
		out_last_q  <= out_last_d;
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.token_kind   = out_kind_q;
	assign out_ch.indent_level = out_level_q;
	assign out_ch.line_number  = out_line_q;
	assign out_ch.last         = out_last_q;

endmodule
